>>> hdl/gtgd_pkg.sv
// Shared types, codes and reset values for the gyro tilt gesture detector.
// Used by gtgd_cfg, gtgd_core and gyro_tilt_gesture_detector_top; depends on nothing.

package gtgd_pkg;

    // Widths of the stream words and of the register address.
    localparam int DataInWidth  = 40;
    localparam int DataOutWidth = 8;
    localparam int ReqWidth     = 3;
    localparam int AddrWidth    = 5;

    // Request kinds carried on the input tuser.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_UPDATE    = 3'd1;
    localparam logic [2:0] REQ_TAKE_FWD  = 3'd2;
    localparam logic [2:0] REQ_TAKE_BACK = 3'd3;
    localparam logic [2:0] REQ_TAKE_ACT  = 3'd4;
    localparam logic [2:0] REQ_CLEAR     = 3'd5;

    // Sensor command reported with each result.
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_WAKE   = 2'd1;
    localparam logic [1:0] CMD_SLEEP  = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    // Tilt modes; any other nonzero mode behaves as normal.
    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_INVERTED = 2'd2;

    // Screen orientations; other codes use the x axis unsigned by mode.
    localparam logic [2:0] ORIENT_PORTRAIT = 3'd0;
    localparam logic [2:0] ORIENT_INVERTED = 3'd1;
    localparam logic [2:0] ORIENT_LAND_CW  = 3'd2;
    localparam logic [2:0] ORIENT_LAND_CCW = 3'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_IMU_PRESENT    = 3'd0;
    localparam logic [2:0] REG_RATE_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_NEUTRAL_RATE   = 3'd2;
    localparam logic [2:0] REG_RETRIGGER_MS   = 3'd3;
    localparam logic [2:0] REG_POLL_INTERVAL  = 3'd4;
    localparam logic [2:0] REG_SETTLE_MS      = 3'd5;

    // Register reset values.
    localparam logic [14:0] RATE_THRESHOLD_RST = 15'd1600;
    localparam logic [14:0] NEUTRAL_RATE_RST   = 15'd480;
    localparam logic [15:0] RETRIGGER_MS_RST   = 16'd500;
    localparam logic [15:0] POLL_INTERVAL_RST  = 16'd50;
    localparam logic [15:0] SETTLE_MS_RST      = 16'd300;

    typedef struct packed {
        logic        imu_present;
        logic [14:0] rate_threshold;
        logic [14:0] neutral_rate;
        logic [15:0] retrigger_ms;
        logic [15:0] sample_gap_ms;
        logic [15:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         tilt_mode;
        logic [2:0]         screen_orientation;
        logic               reading_active;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic               sample_ok;
        logic               command_ok;
    } item_t;

    typedef struct packed {
        logic       flag_value;
        logic [1:0] sensor_command;
        logic       forward_fired;
        logic       back_fired;
        logic       is_awake;
        logic       holding_tilt;
    } result_t;

endpackage

>>> hdl/gyro_tilt_gesture_detector_top.sv
// Top level of the gyro tilt gesture detector: input register, update core, result register.
// Depends on gtgd_pkg, gtgd_cfg and gtgd_core.
//
// Channel   Direction  Handshake         Content
// s_*       in         tvalid/tready     request word: kind in tuser, sample fields in tdata
// m_*       out        tvalid/tready     result word: flags and sensor command in tdata
// APB       in         psel/penable      six configuration registers at 4*index
//
// The block takes one word per clock cycle while s_tready is high. A word is
// captured in the input register, processed there by the core, and its result
// moves into the result register when both stages advance, that is when the
// result register is empty or being taken; an empty input register also takes
// a word, which lets a new word enter while a finished result still waits on
// m_tready. A stall on m_tready holds the result and any waiting word; s_tready
// drops only when both stages are full. Reset clears all state, timestamps and
// valid flags; registers return to their reset values.

module gyro_tilt_gesture_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: tilt_mode[1:0], screen_orientation[4:2], reading_active[5],
    // rate_x[21:6], rate_y[37:22], sample_ok[38], command_ok[39]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gtgd_pkg::DataInWidth-1:0]    s_tdata,
    // s_tuser: req_type[2:0]
    input  logic [gtgd_pkg::ReqWidth-1:0]       s_tuser,
    // m_tdata: flag_value[0], sensor_command[2:1], forward_fired[3],
    // back_fired[4], is_awake[5], holding_tilt[6], zero[7]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gtgd_pkg::DataOutWidth-1:0]   m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gtgd_pkg::AddrWidth-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import gtgd_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;

    gtgd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Both stages move when the result register is free or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    gtgd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.req_type           <= s_tuser;
            in_item_reg.tilt_mode          <= s_tdata[1:0];
            in_item_reg.screen_orientation <= s_tdata[4:2];
            in_item_reg.reading_active     <= s_tdata[5];
            in_item_reg.rate_x             <= s_tdata[21:6];
            in_item_reg.rate_y             <= s_tdata[37:22];
            in_item_reg.sample_ok          <= s_tdata[38];
            in_item_reg.command_ok         <= s_tdata[39];
        end
        if (fire)
            out_result_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.holding_tilt,
                       out_result_reg.is_awake,
                       out_result_reg.back_fired,
                       out_result_reg.forward_fired,
                       out_result_reg.sensor_command,
                       out_result_reg.flag_value};

    // A single update never fires both directions.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("forward and back fired together");

    // A fired tilt comes only from a consumed sample and leaves the block awake and holding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[3] || m_tdata[4])) |->
            (m_tdata[2:1] == CMD_SAMPLE && m_tdata[5] && m_tdata[6]))
        else $error("tilt fired without a consumed sample or hold");

    // The input side stalls only when both stages are full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && in_valid_reg))
        else $error("input stalled with room in the pipeline");

    // A taken result is followed by the next word whenever one was waiting in the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && in_valid_reg) |=> m_tvalid)
        else $error("result register emptied while a word was pending");

endmodule

>>> hdl/gtgd_cfg.sv
// Configuration register file of the tilt detector, written and read over APB.
// Depends on gtgd_pkg.

module gtgd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtgd_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gtgd_pkg::cfg_t                cfg
);
    import gtgd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[AddrWidth-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imu_present    <= 1'b0;
            cfg_reg.rate_threshold <= RATE_THRESHOLD_RST;
            cfg_reg.neutral_rate   <= NEUTRAL_RATE_RST;
            cfg_reg.retrigger_ms   <= RETRIGGER_MS_RST;
            cfg_reg.sample_gap_ms  <= POLL_INTERVAL_RST;
            cfg_reg.settle_ms      <= SETTLE_MS_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_IMU_PRESENT:    cfg_reg.imu_present    <= pwdata[0];
                REG_RATE_THRESHOLD: cfg_reg.rate_threshold <= pwdata[14:0];
                REG_NEUTRAL_RATE:   cfg_reg.neutral_rate   <= pwdata[14:0];
                REG_RETRIGGER_MS:   cfg_reg.retrigger_ms   <= pwdata[15:0];
                REG_POLL_INTERVAL:  cfg_reg.sample_gap_ms  <= pwdata[15:0];
                REG_SETTLE_MS:      cfg_reg.settle_ms      <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_IMU_PRESENT:    prdata = {31'd0, cfg_reg.imu_present};
            REG_RATE_THRESHOLD: prdata = {17'd0, cfg_reg.rate_threshold};
            REG_NEUTRAL_RATE:   prdata = {17'd0, cfg_reg.neutral_rate};
            REG_RETRIGGER_MS:   prdata = {16'd0, cfg_reg.retrigger_ms};
            REG_POLL_INTERVAL:  prdata = {16'd0, cfg_reg.sample_gap_ms};
            REG_SETTLE_MS:      prdata = {16'd0, cfg_reg.settle_ms};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/gtgd_core.sv
// Tilt detector state and the single-pass update logic for one word.
// Depends on gtgd_pkg.

module gtgd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  gtgd_pkg::item_t   item,
    input  gtgd_pkg::cfg_t    cfg,
    output gtgd_pkg::result_t result
);
    import gtgd_pkg::*;

    logic [31:0] ms_reg, ms_next;
    logic [31:0] wake_reg, wake_next;
    logic [31:0] poll_reg, poll_next;
    logic [31:0] trig_reg, trig_next;
    logic        awake_reg, awake_next;
    logic        tilt_reg, tilt_next;
    logic        fwd_pend_reg, fwd_pend_next;
    logic        back_pend_reg, back_pend_next;
    logic        act_pend_reg, act_pend_next;

    logic [31:0]        since_wake, since_poll, since_trig;
    logic               inv;
    logic signed [16:0] gx, gy, axis, mag, thr, neutral;

    assign since_wake = ms_reg - wake_reg;
    assign since_poll = ms_reg - poll_reg;
    assign since_trig = ms_reg - trig_reg;
    assign inv        = (item.tilt_mode == MODE_INVERTED);
    assign gx         = {item.rate_x[15], item.rate_x};
    assign gy         = {item.rate_y[15], item.rate_y};
    assign thr        = {2'b00, cfg.rate_threshold};
    assign neutral    = {2'b00, cfg.neutral_rate};

    // Axis selection and sign, then its magnitude (17 bits hold +32768).
    always_comb
    begin
        case (item.screen_orientation)
            ORIENT_PORTRAIT: axis = inv ? -gx : gx;
            ORIENT_INVERTED: axis = inv ? gx : -gx;
            ORIENT_LAND_CW:  axis = inv ? gy : -gy;
            ORIENT_LAND_CCW: axis = inv ? -gy : gy;
            default:         axis = gx;
        endcase
        mag = axis[16] ? -axis : axis;
    end

    always_comb
    begin
        ms_next        = ms_reg;
        wake_next      = wake_reg;
        poll_next      = poll_reg;
        trig_next      = trig_reg;
        awake_next     = awake_reg;
        tilt_next      = tilt_reg;
        fwd_pend_next  = fwd_pend_reg;
        back_pend_next = back_pend_reg;
        act_pend_next  = act_pend_reg;
        result.flag_value     = 1'b0;
        result.sensor_command = CMD_NONE;
        result.forward_fired  = 1'b0;
        result.back_fired     = 1'b0;

        case (item.req_type)
            REQ_TICK:
            begin
                ms_next = ms_reg + 32'd1;
            end
            REQ_UPDATE:
            begin
                if (!cfg.imu_present)
                begin
                end
                else if (item.tilt_mode != MODE_OFF && !awake_reg)
                begin
                    result.sensor_command = CMD_WAKE;
                    if (item.command_ok)
                    begin
                        poll_next  = ms_reg;
                        trig_next  = ms_reg;
                        wake_next  = ms_reg;
                        awake_next = 1'b1;
                    end
                end
                else if (item.tilt_mode == MODE_OFF && awake_reg)
                begin
                    result.sensor_command = CMD_SLEEP;
                    if (item.command_ok)
                    begin
                        fwd_pend_next  = 1'b0;
                        back_pend_next = 1'b0;
                        act_pend_next  = 1'b0;
                        tilt_next      = 1'b0;
                        awake_next     = 1'b0;
                    end
                end
                else if (item.tilt_mode != MODE_OFF && item.reading_active
                         && since_wake >= {16'd0, cfg.settle_ms}
                         && since_poll >= {16'd0, cfg.sample_gap_ms})
                begin
                    poll_next             = ms_reg;
                    result.sensor_command = CMD_SAMPLE;
                    if (item.sample_ok)
                    begin
                        if (tilt_reg)
                        begin
                            if (mag < neutral)
                                tilt_next = 1'b0;
                        end
                        else if (since_trig >= {16'd0, cfg.retrigger_ms})
                        begin
                            if (axis > thr)
                            begin
                                fwd_pend_next        = 1'b1;
                                act_pend_next        = 1'b1;
                                tilt_next            = 1'b1;
                                trig_next            = ms_reg;
                                result.forward_fired = 1'b1;
                            end
                            else if (axis < -thr)
                            begin
                                back_pend_next    = 1'b1;
                                act_pend_next     = 1'b1;
                                tilt_next         = 1'b1;
                                trig_next         = ms_reg;
                                result.back_fired = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_TAKE_FWD:
            begin
                result.flag_value = fwd_pend_reg;
                fwd_pend_next     = 1'b0;
            end
            REQ_TAKE_BACK:
            begin
                result.flag_value = back_pend_reg;
                back_pend_next    = 1'b0;
            end
            REQ_TAKE_ACT:
            begin
                result.flag_value = act_pend_reg;
                act_pend_next     = 1'b0;
            end
            REQ_CLEAR:
            begin
                fwd_pend_next  = 1'b0;
                back_pend_next = 1'b0;
                act_pend_next  = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.is_awake     = awake_next;
        result.holding_tilt = tilt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg        <= 32'd0;
            wake_reg      <= 32'd0;
            poll_reg      <= 32'd0;
            trig_reg      <= 32'd0;
            awake_reg     <= 1'b0;
            tilt_reg      <= 1'b0;
            fwd_pend_reg  <= 1'b0;
            back_pend_reg <= 1'b0;
            act_pend_reg  <= 1'b0;
        end
        else if (fire)
        begin
            ms_reg        <= ms_next;
            wake_reg      <= wake_next;
            poll_reg      <= poll_next;
            trig_reg      <= trig_next;
            awake_reg     <= awake_next;
            tilt_reg      <= tilt_next;
            fwd_pend_reg  <= fwd_pend_next;
            back_pend_reg <= back_pend_next;
            act_pend_reg  <= act_pend_next;
        end
    end

endmodule
